@@ sv/fba_pkg.sv @@
package fba_pkg;

  localparam int OP_W      = 2;
  localparam int FRAME_W   = 16;
  localparam int LENGTH_W  = 17;
  localparam int CFG_W     = 16;
  // Bit offsets inside a map word; wide enough for the largest word size.
  localparam int BIT_IDX_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_FREE  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_QUERY = 2'd2,
    OP_NEW   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SPLIT,
    ST_RANGE,
    ST_QUERY,
    ST_SEARCH,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    WU_SET,
    WU_CLEAR,
    WU_SEARCH
  } wu_mode_t;

  typedef struct packed {
    wu_mode_t               mode;
    logic [BIT_IDX_W-1:0]   lo;
    logic [BIT_IDX_W-1:0]   hi;
    logic                   skip_bit0;
  } wu_ctrl_t;

  typedef struct packed {
    logic                   hit;
    logic [BIT_IDX_W-1:0]   idx;
  } wu_stat_t;

endpackage

@@ sv/fba_if.sv @@
interface fba_in_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::OP_W-1:0]      operation;
  logic [fba_pkg::FRAME_W-1:0]   frame;
  logic [fba_pkg::LENGTH_W-1:0]  length;

  modport source (output valid, operation, frame, length, input ready);
  modport sink   (input valid, operation, frame, length, output ready);
endinterface

interface fba_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_allocated;
  logic                          found;
  logic [fba_pkg::FRAME_W-1:0]   new_frame;

  modport source (output valid, is_allocated, found, new_frame, input ready);
  modport sink   (input valid, is_allocated, found, new_frame, output ready);
endinterface

interface fba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::CFG_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/fba_word_unit.sv @@
module fba_word_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0] rd_data,
  input  fba_pkg::wu_ctrl_t    ctrl,
  output logic [WORD_BITS-1:0] wr_data,
  output fba_pkg::wu_stat_t    stat
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] one_hot;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (fba_pkg::BIT_IDX_W'(i) >= ctrl.lo) && (fba_pkg::BIT_IDX_W'(i) <= ctrl.hi);
    end
    cand = rd_data & mask;
    if (ctrl.skip_bit0) begin
      cand[0] = 1'b0;
    end
  end

  // The highest free bit wins, since the search runs downward.
  always_comb begin
    stat.hit = 1'b0;
    stat.idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (cand[i]) begin
        stat.hit = 1'b1;
        stat.idx = fba_pkg::BIT_IDX_W'(i);
      end
    end
  end

  assign one_hot = {{(WORD_BITS-1){1'b0}}, 1'b1} << stat.idx;

  always_comb begin
    case (ctrl.mode)
      fba_pkg::WU_SET:    wr_data = rd_data | mask;
      fba_pkg::WU_CLEAR:  wr_data = rd_data & ~mask;
      fba_pkg::WU_SEARCH: wr_data = stat.hit ? (rd_data & ~one_hot) : rd_data;
      default:            wr_data = rd_data;
    endcase
  end

endmodule

@@ sv/frame_bitmap_allocator_top.sv @@
// Sequence: an accepted request passes ST_DIV and ST_SPLIT, then ST_RANGE over the n map
// words of a range, ST_QUERY for a query or ST_SEARCH down from top_frame (at most
// top_frame/WORD_BITS+1 words) for a new-frame request, then ST_RESP, which registers
// out_rsp.valid once the output slot is free. Throughput: one request at a time, one
// map word per cycle through the word unit. Reset: synchronous; a clearing pass writes
// all MAP_WORDS words to zero while no request is taken; configuration writes are taken.
module frame_bitmap_allocator_top #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  fba_in_if.sink        in_req,
  fba_out_if.source     out_rsp,
  fba_cfg_if.sink       cfg_wr
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW        = $clog2(WORD_BITS);
  localparam int EW        = ($clog2(NUM_FRAMES + 1) > 17) ? $clog2(NUM_FRAMES + 1) : 17;
  localparam int FW        = fba_pkg::FRAME_W;
  localparam int IW        = fba_pkg::BIT_IDX_W;
  // Word index by reciprocal multiply, exact for every 16-bit frame number.
  localparam int K         = FW + LW;
  localparam int PW        = FW + K + 1;
  localparam logic [PW-1:0] RECIP = PW'(((64'(1) << K) + 64'(WORD_BITS) - 64'(1)) / 64'(WORD_BITS));

  fba_pkg::state_t      state_r, state_nxt;
  fba_pkg::op_t         op_r, op_nxt;
  logic [FW-1:0]        target_r, target_nxt;
  logic [EW-1:0]        end_r, end_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [EW-1:0]        base_r, base_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic                 res_alloc_r, res_alloc_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [FW-1:0]        res_frame_r, res_frame_nxt;
  logic [FW-1:0]        top_frame_r;
  logic                 out_valid_r;
  logic                 out_alloc_r;
  logic                 out_found_r;
  logic [FW-1:0]        out_frame_r;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  fba_pkg::wu_ctrl_t    wu_ctrl;
  fba_pkg::wu_stat_t    wu_stat;
  logic [WORD_BITS-1:0] wu_wr_data;

  logic                 accept;
  logic                 slot_free;
  logic [FW-1:0]        search_start;
  logic [EW-1:0]        range_sum;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        quot;
  logic [EW-1:0]        base_calc;
  logic [EW-1:0]        offset_calc;
  logic [EW-1:0]        range_rem;
  logic [IW-1:0]        range_hi;
  logic [EW:0]          base_next_sum;
  logic                 range_last;
  logic                 range_empty;
  logic                 query_oor;

  assign accept     = in_req.valid && in_req.ready;
  assign slot_free  = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == fba_pkg::ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.is_allocated = out_alloc_r;
  assign out_rsp.found        = out_found_r;
  assign out_rsp.new_frame    = out_frame_r;

  // Frames at or above the map count as allocated, so the search starts at the last one.
  assign search_start = (EW'(top_frame_r) >= EW'(NUM_FRAMES)) ? FW'(NUM_FRAMES - 1)
                                                              : top_frame_r;
  assign range_sum    = EW'(in_req.frame) + EW'(in_req.length);

  assign prod         = PW'(target_r) * RECIP;
  assign quot         = prod >> K;
  assign base_calc    = EW'(word_r) * EW'(WORD_BITS);
  assign offset_calc  = EW'(target_r) - base_calc;

  assign range_rem     = end_r - base_r;
  assign range_hi      = (range_rem >= EW'(WORD_BITS)) ? IW'(WORD_BITS - 1)
                                                       : IW'(range_rem - EW'(1));
  assign base_next_sum = {1'b0, base_r} + (EW+1)'(WORD_BITS);
  assign range_last    = (base_next_sum >= {1'b0, end_r});
  assign range_empty   = (EW'(target_r) >= end_r);
  assign query_oor     = (EW'(target_r) >= EW'(NUM_FRAMES));

  always_comb begin
    wu_ctrl.mode      = fba_pkg::WU_SEARCH;
    wu_ctrl.lo        = '0;
    wu_ctrl.hi        = lo_r;
    wu_ctrl.skip_bit0 = (word_r == '0);
    if (state_r == fba_pkg::ST_RANGE) begin
      wu_ctrl.mode      = (op_r == fba_pkg::OP_FREE) ? fba_pkg::WU_SET : fba_pkg::WU_CLEAR;
      wu_ctrl.lo        = lo_r;
      wu_ctrl.hi        = range_hi;
      wu_ctrl.skip_bit0 = 1'b0;
    end
  end

  fba_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .rd_data (rd_data_r),
    .ctrl    (wu_ctrl),
    .wr_data (wu_wr_data),
    .stat    (wu_stat)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        if (word_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = fba_pkg::ST_DIV;
        end
      end
      fba_pkg::ST_DIV: state_nxt = fba_pkg::ST_SPLIT;
      fba_pkg::ST_SPLIT: begin
        case (op_r)
          fba_pkg::OP_FREE, fba_pkg::OP_ALLOC:
            state_nxt = range_empty ? fba_pkg::ST_RESP : fba_pkg::ST_RANGE;
          fba_pkg::OP_QUERY:
            state_nxt = query_oor ? fba_pkg::ST_RESP : fba_pkg::ST_QUERY;
          default:
            state_nxt = fba_pkg::ST_SEARCH;
        endcase
      end
      fba_pkg::ST_RANGE: begin
        if (range_last) begin
          state_nxt = fba_pkg::ST_RESP;
        end
      end
      fba_pkg::ST_QUERY: state_nxt = fba_pkg::ST_RESP;
      fba_pkg::ST_SEARCH: begin
        if (wu_stat.hit || (word_r == '0)) begin
          state_nxt = fba_pkg::ST_RESP;
        end
      end
      fba_pkg::ST_RESP: begin
        if (slot_free) begin
          state_nxt = fba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fba_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    op_nxt        = op_r;
    target_nxt    = target_r;
    end_nxt       = end_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    lo_nxt        = lo_r;
    res_alloc_nxt = res_alloc_r;
    res_found_nxt = res_found_r;
    res_frame_nxt = res_frame_r;
    wr_en         = 1'b0;
    wr_data       = wu_wr_data;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        word_nxt = word_r + AW'(1);
      end
      fba_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt        = fba_pkg::op_t'(in_req.operation);
          target_nxt    = (fba_pkg::op_t'(in_req.operation) == fba_pkg::OP_NEW) ?
                          search_start : in_req.frame;
          end_nxt       = (range_sum > EW'(NUM_FRAMES)) ? EW'(NUM_FRAMES) : range_sum;
          res_alloc_nxt = 1'b0;
          res_found_nxt = 1'b0;
          res_frame_nxt = '0;
        end
      end
      fba_pkg::ST_DIV: begin
        word_nxt = quot[AW-1:0];
      end
      fba_pkg::ST_SPLIT: begin
        base_nxt = base_calc;
        lo_nxt   = offset_calc[IW-1:0];
        if ((op_r == fba_pkg::OP_QUERY) && query_oor) begin
          res_alloc_nxt = 1'b1;
        end
      end
      fba_pkg::ST_RANGE: begin
        wr_en = 1'b1;
        if (!range_last) begin
          word_nxt = word_r + AW'(1);
          base_nxt = base_next_sum[EW-1:0];
          lo_nxt   = '0;
        end
      end
      fba_pkg::ST_QUERY: begin
        res_alloc_nxt = ~rd_data_r[lo_r[LW-1:0]];
      end
      fba_pkg::ST_SEARCH: begin
        if (wu_stat.hit) begin
          wr_en         = 1'b1;
          res_found_nxt = 1'b1;
          res_frame_nxt = FW'(base_r + EW'(wu_stat.idx));
        end else if (word_r != '0) begin
          word_nxt = word_r - AW'(1);
          base_nxt = base_r - EW'(WORD_BITS);
          lo_nxt   = IW'(WORD_BITS - 1);
        end
      end
      default: begin
      end
    endcase
  end

  // The read of the word for the next cycle is issued with its address.
  assign rd_en = (state_nxt == fba_pkg::ST_RANGE) || (state_nxt == fba_pkg::ST_QUERY) ||
                 (state_nxt == fba_pkg::ST_SEARCH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[word_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fba_pkg::ST_CLEAR;
      word_r      <= '0;
      top_frame_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        top_frame_r <= cfg_wr.data;
      end
      if ((state_r == fba_pkg::ST_RESP) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    target_r    <= target_nxt;
    end_r       <= end_nxt;
    base_r      <= base_nxt;
    lo_r        <= lo_nxt;
    res_alloc_r <= res_alloc_nxt;
    res_found_r <= res_found_nxt;
    res_frame_r <= res_frame_nxt;
    if ((state_r == fba_pkg::ST_RESP) && slot_free) begin
      out_alloc_r <= res_alloc_r;
      out_found_r <= res_found_r;
      out_frame_r <= res_frame_r;
    end
  end

endmodule
